// ----- rtl/core/sbpf_pkg.sv -----
package sbpf_pkg;

  // action codes on the slave side
  localparam logic [2:0] ACT_PING       = 3'd0;
  localparam logic [2:0] ACT_READ       = 3'd1;
  localparam logic [2:0] ACT_WRITE      = 3'd2;
  localparam logic [2:0] ACT_SYNC_WRITE = 3'd3;
  localparam logic [2:0] ACT_SYNC_READ  = 3'd4;

  // kind of the sync packet currently open
  localparam logic [1:0] KIND_NONE       = 2'd0;
  localparam logic [1:0] KIND_SYNC_WRITE = 2'd1;
  localparam logic [1:0] KIND_SYNC_READ  = 2'd2;

  // packet bytes
  localparam logic [7:0] HDR_SYNC0     = 8'hFF;
  localparam logic [7:0] HDR_SYNC1     = 8'hFD;
  localparam logic [7:0] HDR_RSVD      = 8'h00;
  localparam logic [7:0] ID_BROADCAST  = 8'hFE;
  localparam logic [7:0] INS_PING      = 8'h01;
  localparam logic [7:0] INS_READ      = 8'h02;
  localparam logic [7:0] INS_WRITE     = 8'h03;
  localparam logic [7:0] INS_SYNC_READ = 8'h82;
  localparam logic [7:0] INS_SYNC_WR   = 8'h83;
  localparam logic [7:0] ADDR_GOAL_POS = 8'd116;
  localparam logic [7:0] ADDR_PRES_POS = 8'd132;
  localparam logic [7:0] RW_SIZE       = 8'h02;
  localparam logic [7:0] SYNC_SIZE     = 8'h04;
  localparam logic [15:0] CRC_POLY     = 16'h8005;

  localparam logic [3:0] JOINT_RESET = 4'd5;
  localparam int unsigned BODY_MAX   = 9;
  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned QPTR_W     = 1;

  // one classified request handed from front to back
  typedef struct packed {
    logic                          reject;
    logic                          hdr;
    logic                          close;
    logic [7:0]                    id;
    logic [15:0]                   len;
    logic [7:0]                    instr;
    logic [3:0]                    nbody;
    logic [BODY_MAX-1:0][7:0]      body;
  } cmd_t;

  // queue status seen by the top level
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // crc-16, poly 0x8005, msb first, one byte
  function automatic logic [15:0] crc_upd(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/sbpf_front.sv -----
module sbpf_front #(
  parameter int unsigned MAX_JOINTS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [3:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        action_i,
  input  logic [7:0]        servo_id_i,
  input  logic [15:0]       reg_address_i,
  input  logic [31:0]       data_value_i,
  input  logic              q_full_i,
  output logic              push_o,
  output sbpf_pkg::cmd_t    push_data_o
);
  import sbpf_pkg::*;

  localparam logic [4:0] MaxJ = 5'(MAX_JOINTS);

  logic [3:0] joint_count_q;
  logic [1:0] open_q, open_d;
  logic [3:0] cnt_q, cnt_d;
  logic [4:0] n_eff;
  logic [1:0] kind;
  logic       accept;
  logic       known;
  logic       foreign;
  logic       fresh;
  logic [3:0] cnt_cur;
  logic       closes;
  cmd_t       cmd;

  // joint count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      joint_count_q <= JOINT_RESET;
    end else if (cfg_we_i) begin
      joint_count_q <= cfg_wdata_i;
    end
  end

  // effective joint count, clamped to 1..MAX_JOINTS
  always_comb begin
    if (joint_count_q == 4'd0) begin
      n_eff = 5'd1;
    end else if ({1'b0, joint_count_q} > MaxJ) begin
      n_eff = MaxJ;
    end else begin
      n_eff = {1'b0, joint_count_q};
    end
  end

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign known      = (action_i <= ACT_SYNC_READ);
  assign kind       = (action_i == ACT_SYNC_WRITE) ? KIND_SYNC_WRITE :
                      (action_i == ACT_SYNC_READ)  ? KIND_SYNC_READ  : KIND_NONE;
  assign foreign    = (open_q != KIND_NONE) && (kind != open_q);
  assign fresh      = (open_q == KIND_NONE);
  assign cnt_cur    = fresh ? 4'd0 : cnt_q;
  assign closes     = ({1'b0, cnt_cur} + 5'd1) >= n_eff;

  // classify the request into a byte plan
  always_comb begin
    cmd        = '0;
    open_d     = open_q;
    cnt_d      = cnt_q;
    cmd.id     = servo_id_i;
    if (foreign) begin
      cmd.reject = 1'b1;
    end else begin
      case (action_i)
        ACT_PING: begin
          cmd.hdr   = 1'b1;
          cmd.close = 1'b1;
          cmd.len   = 16'd3;
          cmd.instr = INS_PING;
        end
        ACT_READ: begin
          cmd.hdr     = 1'b1;
          cmd.close   = 1'b1;
          cmd.len     = 16'd7;
          cmd.instr   = INS_READ;
          cmd.nbody   = 4'd4;
          cmd.body[0] = reg_address_i[7:0];
          cmd.body[1] = reg_address_i[15:8];
          cmd.body[2] = RW_SIZE;
          cmd.body[3] = 8'h00;
        end
        ACT_WRITE: begin
          cmd.hdr     = 1'b1;
          cmd.close   = 1'b1;
          cmd.len     = 16'd7;
          cmd.instr   = INS_WRITE;
          cmd.nbody   = 4'd4;
          cmd.body[0] = reg_address_i[7:0];
          cmd.body[1] = reg_address_i[15:8];
          cmd.body[2] = data_value_i[7:0];
          cmd.body[3] = data_value_i[15:8];
        end
        ACT_SYNC_WRITE, ACT_SYNC_READ: begin
          cmd.close = closes;
          if (fresh) begin
            cmd.hdr   = 1'b1;
            cmd.id    = ID_BROADCAST;
            if (kind == KIND_SYNC_WRITE) begin
              cmd.len     = 16'({n_eff, 2'b00}) + 16'(n_eff) + 16'd7;
              cmd.instr   = INS_SYNC_WR;
              cmd.body[0] = ADDR_GOAL_POS;
              cmd.nbody   = 4'd9;
            end else begin
              cmd.len     = 16'(n_eff) + 16'd7;
              cmd.instr   = INS_SYNC_READ;
              cmd.body[0] = ADDR_PRES_POS;
              cmd.nbody   = 4'd5;
            end
            cmd.body[1] = 8'h00;
            cmd.body[2] = SYNC_SIZE;
            cmd.body[3] = 8'h00;
            cmd.body[4] = servo_id_i;
            cmd.body[5] = data_value_i[7:0];
            cmd.body[6] = data_value_i[15:8];
            cmd.body[7] = data_value_i[23:16];
            cmd.body[8] = data_value_i[31:24];
          end else begin
            cmd.nbody   = (kind == KIND_SYNC_WRITE) ? 4'd5 : 4'd1;
            cmd.body[0] = servo_id_i;
            cmd.body[1] = data_value_i[7:0];
            cmd.body[2] = data_value_i[15:8];
            cmd.body[3] = data_value_i[23:16];
            cmd.body[4] = data_value_i[31:24];
          end
          if (closes) begin
            open_d = KIND_NONE;
            cnt_d  = 4'd0;
          end else begin
            open_d = kind;
            cnt_d  = cnt_cur + 4'd1;
          end
        end
        default: begin
          cmd = '0;
        end
      endcase
    end
  end

  assign push_o      = accept && known;
  assign push_data_o = cmd;

  // open sync packet tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= KIND_NONE;
      cnt_q  <= 4'd0;
    end else if (push_o) begin
      open_q <= open_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ----- rtl/core/sbpf_queue.sv -----
module sbpf_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sbpf_pkg::cmd_t    push_data_i,
  input  logic              pop_i,
  output sbpf_pkg::cmd_t    head_o,
  output sbpf_pkg::qstat_t  stat_o
);
  import sbpf_pkg::*;

  localparam logic [QPTR_W-1:0] PtrLast = QPTR_W'(QDEPTH - 1);

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;
  logic              do_push, do_pop;

  assign stat_o.full  = (cnt_q == (QPTR_W+1)'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/sbpf_back.sv -----
module sbpf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sbpf_pkg::cmd_t    head_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              out_last_o,
  output logic              out_rej_o
);
  import sbpf_pkg::*;

  logic [4:0]  step_q;
  logic [4:0]  total;
  logic        last;
  logic        adv;
  logic [15:0] crc_q, crc_base;
  logic        valid_q;
  logic [7:0]  byte_q;
  logic        last_q, rej_q;
  logic [7:0]  cur_byte;
  logic        is_crc, crc_hi;
  logic [4:0]  j5;
  logic [3:0]  j;

  // byte count of the current request
  assign total = head_i.reject ? 5'd1 :
                 ({1'b0, head_i.hdr, 3'b000} + {1'b0, head_i.nbody} +
                  {3'b000, head_i.close, 1'b0});
  assign last  = (step_q == total - 5'd1);
  assign adv   = !empty_i && (!valid_q || out_ready_i);
  assign pop_o = adv && last;

  assign j5 = step_q - {1'b0, head_i.hdr, 3'b000};
  assign j  = j5[3:0];

  // byte select for the current step
  always_comb begin
    cur_byte = 8'h00;
    is_crc   = 1'b0;
    crc_hi   = 1'b0;
    if (head_i.hdr && step_q < 5'd8) begin
      case (step_q[2:0])
        3'd0:    cur_byte = HDR_SYNC0;
        3'd1:    cur_byte = HDR_SYNC0;
        3'd2:    cur_byte = HDR_SYNC1;
        3'd3:    cur_byte = HDR_RSVD;
        3'd4:    cur_byte = head_i.id;
        3'd5:    cur_byte = head_i.len[7:0];
        3'd6:    cur_byte = head_i.len[15:8];
        3'd7:    cur_byte = head_i.instr;
        default: cur_byte = 8'h00;
      endcase
    end else if (j < head_i.nbody) begin
      cur_byte = head_i.body[j];
    end else begin
      is_crc   = 1'b1;
      crc_hi   = (j != head_i.nbody);
      cur_byte = crc_hi ? crc_q[15:8] : crc_q[7:0];
    end
  end

  assign crc_base = (head_i.hdr && step_q == 5'd0) ? 16'h0000 : crc_q;

  // step counter and running crc
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 5'd0;
      crc_q  <= 16'h0000;
    end else if (adv) begin
      step_q <= last ? 5'd0 : step_q + 5'd1;
      if (!head_i.reject) begin
        if (!is_crc) begin
          crc_q <= crc_upd(crc_base, cur_byte);
        end else if (crc_hi) begin
          crc_q <= 16'h0000;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      byte_q <= head_i.reject ? 8'h00 : cur_byte;
      last_q <= !head_i.reject && is_crc && crc_hi;
      rej_q  <= head_i.reject;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;
  assign out_rej_o   = rej_q;

endmodule

// ----- rtl/core/servo_bus_packet_framer_core.sv -----
// the first byte of a request passes through the request queue and the output byte register to the master side
// throughput: one packet byte per cycle unless m_axis_tready stalls the output register; a request
// is 1 to 19 bytes of the byte sequencer (header 8, body up to 9, crc 2)
// the front takes a request every cycle while the two-entry request queue has room
// reset: asynchronous, active low; no sync packet open, crc zero, joint_count 5
module servo_bus_packet_framer_core #(
  parameter int unsigned MAX_JOINTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] servo_id, [23:8] reg_address, [55:24] data_value
  input  logic [55:0] s_axis_tdata,
  // [2:0] action
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] tx_byte
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast,
  // [0] rejected
  output logic        m_axis_tuser
);
  import sbpf_pkg::*;

  logic   push, pop;
  cmd_t   push_data, head;
  qstat_t q_stat;

  // front: accept and classify requests
  sbpf_front #(
    .MAX_JOINTS(MAX_JOINTS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .action_i     (s_axis_tuser),
    .servo_id_i   (s_axis_tdata[7:0]),
    .reg_address_i(s_axis_tdata[23:8]),
    .data_value_i (s_axis_tdata[55:24]),
    .q_full_i     (q_stat.full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  // request queue
  sbpf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (q_stat)
  );

  // back: byte sequencer with crc
  sbpf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .empty_i    (q_stat.empty),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_byte_o (m_axis_tdata),
    .out_last_o (m_axis_tlast),
    .out_rej_o  (m_axis_tuser)
  );

`ifndef SYNTHESIS
  // a rejection carries no byte and never ends a packet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata == 8'h00) && !m_axis_tlast)
    else $error("rejection result carries packet data");

  // undefined action codes leave the queue untouched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser > ACT_SYNC_READ) && !pop
      |=> $stable(q_stat))
    else $error("undefined action entered the request queue");

  // the queue is never popped while empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("pop from empty request queue");
`endif

endmodule
